// ===== rtl/core/pair_distance_histogram_assert.svh =====
// Assertion macros for the pair distance histogram core.
// Used by pair_distance_histogram.sv; relies on clk and rst_n in scope.
`ifndef PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pdh_pkg.sv =====
// Shared types and constants for the pair distance histogram core.
// No dependencies; imported by pair_distance_histogram.sv.
package pdh_pkg;

    localparam int NUM_BINS   = 256;
    localparam int BIN_AW     = $clog2(NUM_BINS);
    localparam int BIN_CW     = $clog2(NUM_BINS + 1);
    localparam int POS_W      = 24;
    localparam int CNT_W      = 32;
    localparam int ACT_W      = 2;
    localparam int RBIN_W     = 8;
    localparam int USED_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int AXIS_W     = 2;
    localparam int MUL_W      = 27;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int D2_W       = 2 * POS_W + 2;

    localparam logic [POS_W-1:0]  BOX_RST       = '1;
    localparam logic [POS_W-1:0]  BIN_WIDTH_RST = POS_W'(65536);
    localparam logic [USED_W-1:0] BINS_USED_RST = USED_W'(256);

    typedef enum logic [ACT_W-1:0] {
        ACT_PAIR   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } pdh_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_X     = 3'd0,
        CFG_BOX_Y     = 3'd1,
        CFG_BOX_Z     = 3'd2,
        CFG_BIN_WIDTH = 3'd3,
        CFG_BINS_USED = 3'd4,
        CFG_THREE_D   = 3'd5
    } pdh_cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_FOLD,
        S_SQ,
        S_ACC,
        S_EDGE,
        S_ESQ,
        S_CMP,
        S_FOUND,
        S_INC,
        S_RDMEM,
        S_RDOUT
    } pdh_state_t;

endpackage

// ===== rtl/core/pair_distance_histogram.sv =====
// Pair distance histogram core: minimum-image distance, shell search, shell counters.
// Depends on pdh_pkg.sv and pair_distance_histogram_assert.svh.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_stall    action, ax, ay, az, bx, by_pos, bz, read_bin
//   out      source     out_valid / out_stall  bin_value, samples_seen
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// A pair transaction steps each axis through difference, fold, square and
// accumulate, squaring on one shared 27x27 multiplier, then binary searches
// the squared shell edges (edge, edge square, compare per step, on the same
// multiplier), then does a read-modify-write of the shell counter memory.
// A read transaction reads the counter memory, then waits for the output register.
// Sample and clear transactions finish in the accept cycle.
// Reset clears the counters through per-shell valid bits; a clear item does the same.
// in_stall is high while a transaction is being worked; out_stall holds the result.
`include "pair_distance_histogram_assert.svh"

module pair_distance_histogram (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pdh_pkg::ACT_W-1:0]         action,
    input  logic [pdh_pkg::POS_W-1:0]         ax,
    input  logic [pdh_pkg::POS_W-1:0]         ay,
    input  logic [pdh_pkg::POS_W-1:0]         az,
    input  logic [pdh_pkg::POS_W-1:0]         bx,
    input  logic [pdh_pkg::POS_W-1:0]         by_pos,
    input  logic [pdh_pkg::POS_W-1:0]         bz,
    input  logic [pdh_pkg::RBIN_W-1:0]        read_bin,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pdh_pkg::CNT_W-1:0]         bin_value,
    output logic [pdh_pkg::CNT_W-1:0]         samples_seen,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [pdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pdh_pkg::*;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [PROD_W-1:0] EDGE_BIG = PROD_W'(1) << MUL_W;

    // configuration
    logic [POS_W-1:0]  box_x_reg, box_y_reg, box_z_reg, bin_width_reg;
    logic [USED_W-1:0] bins_used_reg;
    logic              three_d_reg;

    // control
    pdh_state_t          state_reg, state_next;
    logic [AXIS_W-1:0]   axis_reg, axis_next;
    logic [BIN_CW-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    sample_total_reg, sample_total_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;

    // payload
    logic [POS_W-1:0]        ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [POS_W:0]   diff_reg, diff_next;
    logic [POS_W-1:0]        mag_reg, mag_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [D2_W-1:0]         d2_reg, d2_next;
    logic                    big_reg, big_next;
    logic [BIN_AW-1:0]       addr_reg, addr_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic [CNT_W-1:0]        bin_value_reg, samples_seen_reg;

    // memory
    logic [CNT_W-1:0]  mem [NUM_BINS];
    logic [CNT_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [BIN_AW-1:0] rd_addr;
    logic              mem_we;
    logic [CNT_W-1:0]  inc_value;

    // shared datapath signals
    logic                    in_acc;
    logic                    out_load;
    logic [BIN_CW-1:0]       used_c;
    logic [POS_W-1:0]        a_sel, b_sel, len_sel;
    logic signed [POS_W+1:0] diff_w, len_w, twice_w, fold_w, abs_w;
    logic [D2_W-1:0]         d2_sum;
    logic [BIN_CW:0]         mid_sum;
    logic [BIN_CW-1:0]       mid_c;
    logic                    hit_c;
    logic [BIN_CW-1:0]       lo_srch, hi_srch;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_load  = (state_reg == S_RDOUT) && (!out_valid_reg || !out_stall);

    assign out_valid    = out_valid_reg;
    assign bin_value    = bin_value_reg;
    assign samples_seen = samples_seen_reg;

    // Clamp the shell count to the number of counters present.
    assign used_c = (32'(bins_used_reg) > NUM_BINS) ? BIN_CW'(NUM_BINS)
                                                    : BIN_CW'(bins_used_reg);

    // Per-axis operand selection for the shared difference and fold steps.
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                a_sel   = ax_reg;
                b_sel   = bx_reg;
                len_sel = box_x_reg;
            end
            2'd1:
            begin
                a_sel   = ay_reg;
                b_sel   = by_reg;
                len_sel = box_y_reg;
            end
            default:
            begin
                a_sel   = az_reg;
                b_sel   = bz_reg;
                len_sel = box_z_reg;
            end
        endcase
    end

    // Fold the difference once into the minimum image; compare 2*d against the box.
    always_comb
    begin
        diff_w  = (POS_W+2)'(diff_reg);
        len_w   = signed'({2'b00, len_sel});
        twice_w = diff_w <<< 1;
        if (twice_w > len_w)
            fold_w = diff_w - len_w;
        else if (twice_w < -len_w)
            fold_w = diff_w + len_w;
        else
            fold_w = diff_w;
        abs_w = fold_w[POS_W+1] ? -fold_w : fold_w;
    end

    assign d2_sum = d2_reg + prod_reg[D2_W-1:0];

    // Binary search for the first shell whose squared outer edge reaches d2.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c   = mid_sum[BIN_CW:1];
    assign hit_c   = big_reg || (prod_reg >= PROD_W'(d2_reg));

    always_comb
    begin
        lo_srch = lo_reg;
        hi_srch = hi_reg;
        if (hit_c)
            hi_srch = mid_reg;
        else
            lo_srch = mid_reg + BIN_CW'(1);
    end

    // Shared multiplier, registered into prod_reg.
    assign mul_p = mul_a * mul_b;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        ACT_PAIR: state_next = S_DIFF;
                        ACT_READ: state_next = S_RDMEM;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_DIFF:  state_next = S_FOLD;
            S_FOLD:  state_next = S_SQ;
            S_SQ:    state_next = S_ACC;
            S_ACC:
            begin
                if (axis_reg != AXIS_W'(2))
                    state_next = S_DIFF;
                else if ((d2_sum != '0) && (used_c != '0))
                    state_next = S_EDGE;
                else
                    state_next = S_IDLE;
            end
            S_EDGE:  state_next = S_ESQ;
            S_ESQ:   state_next = S_CMP;
            S_CMP:   state_next = (lo_srch < hi_srch) ? S_EDGE : S_FOUND;
            S_FOUND: state_next = (lo_reg < used_c) ? S_INC : S_IDLE;
            S_INC:   state_next = S_IDLE;
            S_RDMEM: state_next = S_RDOUT;
            S_RDOUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values and multiplier operands.
    always_comb
    begin
        axis_next         = axis_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        sample_total_next = sample_total_reg;
        valid_next        = valid_reg;
        diff_next         = diff_reg;
        mag_next          = mag_reg;
        d2_next           = d2_reg;
        big_next          = big_reg;
        addr_next         = addr_reg;
        rd_ok_next        = rd_ok_reg;
        mul_a             = '0;
        mul_b             = '0;
        mem_we            = 1'b0;
        rd_addr           = addr_reg;
        inc_value         = rd_valid_reg ? ((rd_data_reg == CNT_MAX) ? CNT_MAX
                                            : rd_data_reg + CNT_W'(1))
                                         : CNT_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        ACT_PAIR:
                        begin
                            axis_next = '0;
                            d2_next   = '0;
                        end
                        ACT_SAMPLE:
                        begin
                            if (sample_total_reg != CNT_MAX)
                                sample_total_next = sample_total_reg + CNT_W'(1);
                        end
                        ACT_READ:
                        begin
                            addr_next  = BIN_AW'(read_bin);
                            rd_ok_next = (32'(read_bin) < NUM_BINS);
                        end
                        default:
                        begin
                            // clear: drop every shell and the sample count
                            sample_total_next = '0;
                            valid_next        = '0;
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                diff_next = signed'({1'b0, a_sel}) - signed'({1'b0, b_sel});
            end
            S_FOLD:
            begin
                if ((axis_reg == AXIS_W'(2)) && !three_d_reg)
                    mag_next = '0;
                else
                    mag_next = abs_w[POS_W-1:0];
            end
            S_SQ:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            S_ACC:
            begin
                d2_next   = d2_sum;
                axis_next = axis_reg + AXIS_W'(1);
                lo_next   = '0;
                hi_next   = used_c;
            end
            S_EDGE:
            begin
                mid_next = mid_c;
                mul_a    = MUL_W'(mid_c) + MUL_W'(1);
                mul_b    = MUL_W'(bin_width_reg);
            end
            S_ESQ:
            begin
                // an edge at or above 2^27 exceeds any squared distance
                big_next = (prod_reg >= EDGE_BIG);
                mul_a    = prod_reg[MUL_W-1:0];
                mul_b    = prod_reg[MUL_W-1:0];
            end
            S_CMP:
            begin
                lo_next = lo_srch;
                hi_next = hi_srch;
            end
            S_FOUND:
            begin
                rd_addr = lo_reg[BIN_AW-1:0];
            end
            S_INC:
            begin
                rd_addr           = lo_reg[BIN_AW-1:0];
                mem_we            = 1'b1;
                valid_next[rd_addr] = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            mid_reg          <= '0;
            out_valid_reg    <= 1'b0;
            sample_total_reg <= '0;
            valid_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            axis_reg         <= axis_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            mid_reg          <= mid_next;
            out_valid_reg    <= out_valid_next;
            sample_total_reg <= sample_total_next;
            valid_reg        <= valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg     <= BOX_RST;
            box_y_reg     <= BOX_RST;
            box_z_reg     <= BOX_RST;
            bin_width_reg <= BIN_WIDTH_RST;
            bins_used_reg <= BINS_USED_RST;
            three_d_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_X:     box_x_reg     <= cfg_data[POS_W-1:0];
                CFG_BOX_Y:     box_y_reg     <= cfg_data[POS_W-1:0];
                CFG_BOX_Z:     box_z_reg     <= cfg_data[POS_W-1:0];
                CFG_BIN_WIDTH: bin_width_reg <= cfg_data[POS_W-1:0];
                CFG_BINS_USED: bins_used_reg <= cfg_data[USED_W-1:0];
                CFG_THREE_D:   three_d_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg <= ax;
            ay_reg <= ay;
            az_reg <= az;
            bx_reg <= bx;
            by_reg <= by_pos;
            bz_reg <= bz;
        end
        diff_reg <= diff_next;
        mag_reg  <= mag_next;
        prod_reg <= mul_p;
        d2_reg   <= d2_next;
        big_reg  <= big_next;
        addr_reg <= addr_next;
        rd_ok_reg <= rd_ok_next;
        if (out_load)
        begin
            bin_value_reg    <= (rd_ok_reg && rd_valid_reg) ? rd_data_reg : '0;
            samples_seen_reg <= sample_total_reg;
        end
    end

    // Shell counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[rd_addr] <= inc_value;
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    `PDH_ASSERT_SAME(a_search_bounds,
        (state_reg == S_EDGE) || (state_reg == S_ESQ) || (state_reg == S_CMP),
        (lo_reg < hi_reg) && (hi_reg <= used_c),
        "shell search left its bounds")
    `PDH_ASSERT_SAME(a_search_nonzero,
        (state_reg == S_EDGE) || (state_reg == S_ESQ) || (state_reg == S_CMP),
        d2_reg != '0,
        "shell search started on a zero distance")
    `PDH_ASSERT_SAME(a_inc_in_range,
        mem_we,
        lo_reg < used_c,
        "counter update outside the shells in use")
    `PDH_ASSERT_NEXT(a_clear_empties,
        in_acc && (action == ACT_CLEAR),
        (sample_total_reg == '0) && (valid_reg == '0),
        "clear left counts behind")
    `PDH_ASSERT_SAME(a_out_from_read,
        $rose(out_valid_reg),
        $past(state_reg) == S_RDOUT,
        "result raised outside a read")

endmodule
